// ===== sv/memory_write_pattern_generator_assert.svh =====
// Assertion macros for the memory write pattern generator.
`ifndef MEMORY_WRITE_PATTERN_GENERATOR_ASSERT_SVH
`define MEMORY_WRITE_PATTERN_GENERATOR_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while in reset.
`define MWPG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwpg: same-cycle check failed");
// Next-cycle implication, disabled while in reset.
`define MWPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwpg: next-cycle check failed");
`else
`define MWPG_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MWPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/mwpg_pkg.sv =====
// Shared types and constants for the memory write pattern generator.
package mwpg_pkg;

    localparam int BEAT_BYTES_DEF    = 32;
    localparam int PATTERN_BYTES_DEF = 4096;
    localparam int BURST_BYTES_DEF   = 4096;

    localparam int LANES     = 4;
    localparam int LANE_W    = 64;
    localparam int ADDR_W    = 64;
    localparam int STEP_W    = 32;
    localparam int LEN_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_VAL_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADDRESS  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SET  = 2'd1,
        PH_DATA = 2'd2,
        PH_WAIT = 2'd3
    } phase_t;

    typedef logic [LANES-1:0][LANE_W-1:0] beat_t;

    typedef struct packed {
        logic start_req;
        logic sink_ready;
        logic write_complete;
    } in_item_t;

    typedef struct packed {
        logic              run_done;
        logic              write_request;
        logic [ADDR_W-1:0] write_address;
        logic [LEN_W-1:0]  burst_length;
        logic              beat_valid;
        logic [LANE_W-1:0] beat_lane0;
        logic [LANE_W-1:0] beat_lane1;
        logic [LANE_W-1:0] beat_lane2;
        logic [LANE_W-1:0] beat_lane3;
    } out_item_t;

endpackage

// ===== sv/mwpg_beat_gen.sv =====
// Pattern beat builder: beat bytes from the pattern pointer and the advanced pointer.
module mwpg_beat_gen
    import mwpg_pkg::*;
#(
    parameter int BEAT_BYTES    = BEAT_BYTES_DEF,
    parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
    localparam int PTR_W        = $clog2(PATTERN_BYTES)
)(
    input  logic [PTR_W-1:0] pointer,
    output beat_t            beat,
    output logic [PTR_W-1:0] pointer_next
);

    localparam logic [PTR_W:0] PATTERN_LEN = (PTR_W+1)'(PATTERN_BYTES);
    localparam logic [PTR_W:0] BEAT_LEN    = (PTR_W+1)'(BEAT_BYTES);

    logic [PTR_W:0] advance_sum;

    // Each byte index stays below twice the pattern length, so one subtract wraps it.
    always_comb
    begin
        logic [PTR_W:0] idx;
        beat = '0;
        idx  = '0;
        for (int i = 0; i < BEAT_BYTES; i++)
        begin
            idx = {1'b0, pointer} + (PTR_W+1)'(i);
            if (idx >= PATTERN_LEN)
            begin
                idx = idx - PATTERN_LEN;
            end
            beat[i >> 3][(i & 7) * 8 +: 8] = idx[7:0];
        end
    end

    always_comb
    begin
        advance_sum = {1'b0, pointer} + BEAT_LEN;
        if (advance_sum >= PATTERN_LEN)
        begin
            advance_sum = advance_sum - PATTERN_LEN;
        end
        pointer_next = advance_sum[PTR_W-1:0];
    end

endmodule

// ===== sv/memory_write_pattern_generator.sv =====
// Top level of the memory write pattern generator: tick pipeline, burst sequencer, registers.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, in_item (one tick)    | sink
//  out     | out_valid, out_ready, out_item (outputs)  | source
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_value| sink
//
// One tick transaction is taken every cycle while the out channel does not stall; its result
// passes through the input register, then the sequencer updates the held output registers.
// The held output registers are the result register, so a stalled out channel holds
// the input register, which in turn drops in_ready. Configuration is always ready.
// After reset the sequencer is idle; no clearing pass is needed.
`include "memory_write_pattern_generator_assert.svh"
module memory_write_pattern_generator
    import mwpg_pkg::*;
#(
    parameter int BEAT_BYTES    = BEAT_BYTES_DEF,
    parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
    parameter int BURST_BYTES   = BURST_BYTES_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_VAL_W-1:0] cfg_value
);

    localparam int PTR_W = $clog2(PATTERN_BYTES);
    localparam logic [LEN_W-1:0] BURST_LEN = LEN_W'(BURST_BYTES);
    localparam logic [LEN_W-1:0] BEAT_LEN  = LEN_W'(BEAT_BYTES);

    // configuration registers
    logic [ADDR_W-1:0] base_address_reg;
    logic [STEP_W-1:0] address_step_reg;
    logic [ADDR_W-1:0] max_address_reg;

    // input register
    logic     s1_valid_reg;
    in_item_t s1_item_reg;

    // sequencer state and held outputs
    phase_t            phase_reg,        phase_next;
    logic [ADDR_W-1:0] write_offset_reg, write_offset_next;
    logic [PTR_W-1:0]  pointer_reg,      pointer_next;
    logic [LEN_W-1:0]  bytes_sent_reg,   bytes_sent_next;
    logic              run_done_reg,     run_done_next;
    logic              write_req_reg,    write_req_next;
    logic              beat_valid_reg,   beat_valid_next;
    logic [ADDR_W-1:0] address_reg,      address_next;
    logic [LEN_W-1:0]  length_reg,       length_next;
    beat_t             beat_reg,         beat_next;
    logic              out_valid_reg;

    logic             advance;
    logic [ADDR_W:0]  offset_sum;
    logic             over_limit;
    beat_t            gen_beat;
    logic [PTR_W-1:0] gen_pointer;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
            address_step_reg <= '0;
            max_address_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS: base_address_reg <= cfg_value;
                CFG_ADDRESS_STEP: address_step_reg <= cfg_value[STEP_W-1:0];
                CFG_MAX_ADDRESS:  max_address_reg  <= cfg_value;
                default:          ; // drop writes beyond the register list
            endcase
        end
    end

    mwpg_beat_gen #(
        .BEAT_BYTES    (BEAT_BYTES),
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_beat_gen (
        .pointer      (pointer_reg),
        .beat         (gen_beat),
        .pointer_next (gen_pointer)
    );

    // A sum carrying out of 64 bits counts as beyond the limit.
    assign offset_sum = {1'b0, write_offset_reg} + {{(ADDR_W-STEP_W+1){1'b0}}, address_step_reg};
    assign over_limit = offset_sum[ADDR_W] || (offset_sum[ADDR_W-1:0] > max_address_reg);

    always_comb
    begin
        phase_next        = phase_reg;
        write_offset_next = write_offset_reg;
        pointer_next      = pointer_reg;
        bytes_sent_next   = bytes_sent_reg;
        run_done_next     = run_done_reg;
        write_req_next    = write_req_reg;
        beat_valid_next   = beat_valid_reg;
        address_next      = address_reg;
        length_next       = length_reg;
        beat_next         = beat_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                run_done_next     = 1'b0;
                write_req_next    = 1'b0;
                beat_valid_next   = 1'b0;
                address_next      = '0;
                length_next       = '0;
                beat_next         = '0;
                write_offset_next = '0;
                pointer_next      = '0;
                bytes_sent_next   = '0;
                if (s1_item_reg.start_req)
                begin
                    phase_next = PH_SET;
                end
            end
            PH_SET:
            begin
                if (over_limit)
                begin
                    run_done_next = 1'b1;
                    phase_next    = PH_IDLE;
                end
                else
                begin
                    address_next      = base_address_reg + write_offset_reg;
                    length_next       = BURST_LEN;
                    write_offset_next = offset_sum[ADDR_W-1:0];
                    write_req_next    = 1'b1;
                    phase_next        = PH_DATA;
                end
            end
            PH_DATA:
            begin
                write_req_next = 1'b0;
                if (s1_item_reg.sink_ready)
                begin
                    if (bytes_sent_reg >= BURST_LEN)
                    begin
                        phase_next      = PH_WAIT;
                        bytes_sent_next = '0;
                        beat_valid_next = 1'b0;
                    end
                    else
                    begin
                        beat_next       = gen_beat;
                        pointer_next    = gen_pointer;
                        bytes_sent_next = bytes_sent_reg + BEAT_LEN;
                        beat_valid_next = 1'b1;
                    end
                end
            end
            PH_WAIT:
            begin
                if (s1_item_reg.write_complete)
                begin
                    phase_next = PH_SET;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_IDLE;
            run_done_reg   <= 1'b0;
            write_req_reg  <= 1'b0;
            beat_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_valid_reg && advance)
            begin
                out_valid_reg  <= 1'b1;
                phase_reg      <= phase_next;
                run_done_reg   <= run_done_next;
                write_req_reg  <= write_req_next;
                beat_valid_reg <= beat_valid_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and counters need no reset: the idle tick clears them before use.
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_valid_reg && advance)
        begin
            write_offset_reg <= write_offset_next;
            pointer_reg      <= pointer_next;
            bytes_sent_reg   <= bytes_sent_next;
            address_reg      <= address_next;
            length_reg       <= length_next;
            beat_reg         <= beat_next;
        end
    end

    always_comb
    begin
        out_item.run_done      = run_done_reg;
        out_item.write_request = write_req_reg;
        out_item.write_address = address_reg;
        out_item.burst_length  = length_reg;
        out_item.beat_valid    = beat_valid_reg;
        out_item.beat_lane0    = beat_reg[0];
        out_item.beat_lane1    = beat_reg[1];
        out_item.beat_lane2    = beat_reg[2];
        out_item.beat_lane3    = beat_reg[3];
    end

    `MWPG_ASSERT_NOW(a_req_has_burst, clk, rst_n, write_req_reg, !run_done_reg && length_reg == BURST_LEN && phase_reg == PH_DATA)
    `MWPG_ASSERT_NOW(a_valid_in_data, clk, rst_n, beat_valid_reg, phase_reg == PH_DATA)
    `MWPG_ASSERT_NOW(a_done_is_idle, clk, rst_n, run_done_reg, phase_reg == PH_IDLE)
    `MWPG_ASSERT_NEXT(a_stall_holds_state, clk, rst_n, out_valid_reg && !out_ready, $stable(phase_reg) && $stable(beat_reg))

endmodule
